@@ rtl/fqwc_pkg.sv @@
// Shared types and constants of the flow queue window classifier.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fqwc_pkg;

   localparam int MODE_W      = 2;
   localparam int FID_W       = 6;
   localparam int OCC_W       = 32;
   localparam int SCNT_W      = 4;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FORGET = 2'd2;

   localparam logic [OCC_W-1:0] THRESH_RESET = 32'd65536;

   // one beat of sample data into the window scan
   typedef struct packed {
      logic             clear;
      logic             valid;
      logic [OCC_W-1:0] data;
   } scan_ctl_type;

   typedef struct packed {
      logic [OCC_W-1:0] peak;
      logic             varies;
   } scan_result_type;

endpackage

`default_nettype wire

@@ rtl/fqwc_sample_ram.sv @@
// Sample store: one write port, one read port, registered read data.
// Depends on fqwc_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module fqwc_sample_ram
   import fqwc_pkg::*;
#(
   parameter int DEPTH = 512
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [OCC_W-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [OCC_W-1:0]           rd_data
);

   logic [OCC_W-1:0] mem [DEPTH];
   logic [OCC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/fqwc_flow_table.sv @@
// Per-flow count and ring head memory with a clearing pass after reset.
// Depends on fqwc_pkg (imported for house consistency).
`timescale 1ns / 1ps
`default_nettype none

module fqwc_flow_table
   import fqwc_pkg::*;
#(
   parameter int FLOWS   = 64,
   parameter int ENTRY_W = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   output logic                            busy,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(FLOWS)-1:0]   rd_addr,
   output logic      [ENTRY_W-1:0]         rd_data,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(FLOWS)-1:0]   wr_addr,
   input  wire logic [ENTRY_W-1:0]         wr_data
);

   localparam int FLOW_W = $clog2(FLOWS);

   logic [ENTRY_W-1:0] mem [FLOWS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               clr_busy_ff;
   logic               clr_busy_in;
   logic [FLOW_W-1:0]  clr_idx_ff;
   logic [FLOW_W-1:0]  clr_idx_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + FLOW_W'(1);
         if (clr_idx_ff == FLOW_W'(FLOWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // clear one entry a cycle, then take normal writes
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

@@ rtl/fqwc_window_scan.sv @@
// Running peak and all-equal check over the sample beats of one window.
// Depends on fqwc_pkg for scan_ctl_type and scan_result_type.
`timescale 1ns / 1ps
`default_nettype none

module fqwc_window_scan
   import fqwc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire scan_ctl_type    ctl,
   output scan_result_type      res
);

   logic             have_ff;
   logic             have_in;
   logic             varies_ff;
   logic             varies_in;
   logic [OCC_W-1:0] peak_ff;
   logic [OCC_W-1:0] peak_in;
   logic [OCC_W-1:0] first_ff;
   logic [OCC_W-1:0] first_in;

   always_comb begin
      have_in   = have_ff;
      varies_in = varies_ff;
      peak_in   = peak_ff;
      first_in  = first_ff;
      if (ctl.clear) begin
         have_in   = 1'b0;
         varies_in = 1'b0;
         peak_in   = '0;
      end else if (ctl.valid) begin
         if (!have_ff) begin
            // first slot of the window sets the reference value
            have_in  = 1'b1;
            peak_in  = ctl.data;
            first_in = ctl.data;
         end else begin
            if (ctl.data > peak_ff) begin
               peak_in = ctl.data;
            end
            if (ctl.data != first_ff) begin
               varies_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff   <= 1'b0;
         varies_ff <= 1'b0;
         peak_ff   <= '0;
      end else begin
         have_ff   <= have_in;
         varies_ff <= varies_in;
         peak_ff   <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

   assign res.peak   = peak_ff;
   assign res.varies = varies_ff;

endmodule

`default_nettype wire

@@ rtl/flow_queue_window_classifier_top.sv @@
// Top level of the flow queue window classifier: sequencer, threshold register, output register.
// Depends on fqwc_pkg, fqwc_flow_table, fqwc_sample_ram and fqwc_window_scan.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req channel: one beat per item (mode in tuser, flow id and occupancy in tdata). Every
//   beat gives exactly one rsp beat: interactive, window full, sample count and window
//   peak of the flow, taken after the item's own update. Flow id zero or an id not below
//   FLOWS returns all zeros.
//   csr channel: writes bulk_threshold; csr_ready is always high. Write only while idle.
// Timing
//   One item at a time: a new item is taken only once the sequencer is back in its
//   idle step, after the result of the last one has gone into the output register.
//   The scan reads one sample per cycle through the single read port of the sample
//   memory. rsp_tvalid rises once the whole window has been scanned; for an ignored
//   flow id the scan is skipped and the sequencer goes straight to its final step.
// Reset
//   Synchronous, active high. After reset the flow table runs a clearing pass over all
//   FLOWS entries (one entry a cycle); req_tready stays low until it is done. The
//   threshold returns to 65536. Sample memory is not cleared; only written slots are ever read.
// Backpressure
//   The result sits in an output register; when rsp_tready is low it holds there while
//   the next item is accepted and worked on. The sequencer waits in its final step only
//   when a finished result finds that register still full.

module flow_queue_window_classifier_top
   import fqwc_pkg::*;
#(
   parameter int WINDOW = 8,
   parameter int FLOWS  = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // req_tuser: mode[1:0]
   // req_tdata: flow_id[5:0], occupancy[37:6], zero pad[39:38]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [MODE_W-1:0]       req_tuser,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: interactive[0], window_full[1], sample_count[5:2],
   //            peak_occupancy[37:6], zero pad[39:38]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,
   // csr_data: bulk_threshold
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [OCC_W-1:0]        csr_data
);

   localparam int FLOW_W  = $clog2(FLOWS);
   localparam int HEAD_W  = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int ENTRY_W = CNT_W + HEAD_W;
   localparam int DEPTH   = FLOWS * WINDOW;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PAD_W   = RSP_DATA_W - OCC_W - SCNT_W - 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_META = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // request fields
   logic [MODE_W-1:0] req_mode;
   logic [FID_W-1:0]  req_fid;
   logic [OCC_W-1:0]  req_occ;
   logic              req_fire;
   logic              fid_ok;
   logic [FLOW_W-1:0] fid_idx;

   // sequencer state
   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  occ_in;
   logic [FLOW_W-1:0] flow_ff;
   logic [FLOW_W-1:0] flow_in;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] base_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  rd_left_ff;
   logic [CNT_W-1:0]  rd_left_in;
   logic [HEAD_W-1:0] rd_idx_ff;
   logic [HEAD_W-1:0] rd_idx_in;
   logic              rd_pend_ff;
   logic              rd_pend_in;

   // threshold and output register
   logic [OCC_W-1:0]      thresh_ff;
   logic [OCC_W-1:0]      thresh_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_load;

   // flow table port
   logic               ft_busy;
   logic [ENTRY_W-1:0] ft_rd_data;
   logic               ft_wr_en;
   logic [ENTRY_W-1:0] ft_wr_data;
   logic [CNT_W-1:0]   cur_count;
   logic [HEAD_W-1:0]  cur_head;
   logic [CNT_W-1:0]   new_count;
   logic [HEAD_W-1:0]  new_head;

   // sample memory port
   logic              smp_wr_en;
   logic [ADDR_W-1:0] smp_wr_addr;
   logic              smp_rd_en;
   logic [ADDR_W-1:0] smp_rd_addr;
   logic [OCC_W-1:0]  smp_rd_data;

   // window scan
   scan_ctl_type    scan_ctl;
   scan_result_type scan_res;
   logic            win_full;
   logic            win_inter;

   assign req_mode = req_tuser;
   assign req_fid  = req_tdata[FID_W-1:0];
   assign req_occ  = req_tdata[FID_W+OCC_W-1:FID_W];

   assign req_tready = (state_ff == ST_IDLE) && !ft_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign fid_ok     = (req_fid != '0) && (int'(req_fid) < FLOWS);
   assign fid_idx    = FLOW_W'(req_fid);

   assign cur_count = ft_rd_data[ENTRY_W-1:HEAD_W];
   assign cur_head  = ft_rd_data[HEAD_W-1:0];

   // apply the item to the flow's count and ring head
   always_comb begin
      new_count = cur_count;
      new_head  = cur_head;
      smp_wr_en = 1'b0;
      unique case (mode_ff)
         MODE_ADD: begin
            smp_wr_en = (state_ff == ST_META);
            new_head  = (cur_head == HEAD_W'(WINDOW - 1)) ? '0 : cur_head + HEAD_W'(1);
            new_count = (cur_count < CNT_W'(WINDOW)) ? cur_count + CNT_W'(1) : cur_count;
         end
         MODE_FORGET: begin
            new_count = '0;
            new_head  = '0;
         end
         default: begin
            // query and the unused code leave the flow alone
            new_count = cur_count;
            new_head  = cur_head;
         end
      endcase
   end

   assign ft_wr_en    = (state_ff == ST_META);
   assign ft_wr_data  = {new_count, new_head};
   assign smp_wr_addr = base_ff + ADDR_W'(cur_head);
   assign smp_rd_addr = base_ff + ADDR_W'(rd_idx_ff);
   assign smp_rd_en   = (state_ff == ST_SCAN) && (rd_left_ff != '0);

   assign scan_ctl.clear = req_fire;
   assign scan_ctl.valid = rd_pend_ff;
   assign scan_ctl.data  = smp_rd_data;

   assign win_full  = (cnt_ff == CNT_W'(WINDOW));
   assign win_inter = win_full && (scan_res.peak < thresh_ff) && scan_res.varies;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequencer: accept, read flow entry, update, scan window, deliver
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      occ_in     = occ_ff;
      flow_in    = flow_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      rd_left_in = rd_left_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in = req_mode;
               occ_in  = req_occ;
               flow_in = fid_idx;
               base_in = ADDR_W'(fid_idx) * ADDR_W'(WINDOW);
               if (fid_ok) begin
                  state_in = ST_META;
               end else begin
                  // drop the item; the cleared scan gives an all-zero result
                  cnt_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_META: begin
            cnt_in     = new_count;
            rd_left_in = new_count;
            rd_idx_in  = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_left_ff != '0) begin
               rd_left_in = rd_left_ff - CNT_W'(1);
               rd_idx_in  = rd_idx_ff + HEAD_W'(1);
               rd_pend_in = 1'b1;
            end else begin
               // last beat folds into the scan on this edge
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_valid) begin
         thresh_in = csr_data;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, scan_res.peak, SCNT_W'(cnt_ff), win_full, win_inter};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      occ_ff      <= occ_in;
      flow_ff     <= flow_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   fqwc_flow_table #(
      .FLOWS   (FLOWS),
      .ENTRY_W (ENTRY_W)
   ) u_flow_table (
      .clock   (clock),
      .reset   (reset),
      .busy    (ft_busy),
      .rd_en   (req_fire),
      .rd_addr (fid_idx),
      .rd_data (ft_rd_data),
      .wr_en   (ft_wr_en),
      .wr_addr (flow_ff),
      .wr_data (ft_wr_data)
   );

   fqwc_sample_ram #(
      .DEPTH (DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (smp_wr_addr),
      .wr_data (occ_ff),
      .rd_en   (smp_rd_en),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   fqwc_window_scan u_window_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .res   (scan_res)
   );

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (cnt_ff <= CNT_W'(WINDOW)))
      else $error("sample count exceeds window");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (rd_left_ff != '0)) |->
      ((CNT_W'(rd_idx_ff) + rd_left_ff) == cnt_ff))
      else $error("scan index out of step with count");

   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ((state_ff == ST_META) || (state_ff == ST_DONE)))
      else $error("accepted beat did not start the sequencer");

   a_beat_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("sample beat outside window scan");
`endif

endmodule

`default_nettype wire

@@ verif/fqwc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the flow queue window classifier: watches the req, rsp and csr beats,
// predicts each flow classification and compares it field by field. Depends on fqwc_pkg.

module fqwc_checker
   import fqwc_pkg::*;
#(
   parameter int WINDOW = 8,
   parameter int FLOWS  = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [MODE_W-1:0]     req_tuser,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [OCC_W-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic              interactive;
      logic              window_full;
      logic [SCNT_W-1:0] sample_count;
      logic [OCC_W-1:0]  peak;
   } flow_class_type;

   logic [OCC_W-1:0] window_ring [FLOWS][WINDOW];
   int unsigned      held        [FLOWS];
   int unsigned      next_slot   [FLOWS];
   logic [OCC_W-1:0] bulk_level;
   flow_class_type   pending_classes [$];
   int               mismatches;

   // Apply one item to the flow table copy and return the flow's class after it.
   function automatic flow_class_type classify_flow(input logic [MODE_W-1:0] mode,
                                                    input logic [FID_W-1:0]  fid,
                                                    input logic [OCC_W-1:0]  occ);
      flow_class_type   res;
      logic [OCC_W-1:0] first_sample;
      logic             varies;
      int unsigned      n;
      res    = '0;
      varies = 1'b0;
      if (fid == '0 || int'(fid) >= FLOWS)
         return res;
      case (mode)
         MODE_ADD: begin
            window_ring[fid][next_slot[fid]] = occ;
            next_slot[fid] = (next_slot[fid] + 1) % WINDOW;
            if (held[fid] < WINDOW)
               held[fid] = held[fid] + 1;
         end
         MODE_FORGET: begin
            held[fid]      = 0;
            next_slot[fid] = 0;
         end
         default: ;
      endcase
      n = held[fid];
      first_sample = '0;
      if (n > 0)
         first_sample = window_ring[fid][0];
      for (int i = 0; i < n; i++) begin
         if (window_ring[fid][i] > res.peak)
            res.peak = window_ring[fid][i];
         if (window_ring[fid][i] != first_sample)
            varies = 1'b1;
      end
      res.window_full  = (n == WINDOW);
      res.sample_count = SCNT_W'(n);
      res.interactive  = res.window_full && (res.peak < bulk_level) && varies;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      flow_class_type got;
      flow_class_type want;
      if (reset) begin
         bulk_level = THRESH_RESET;
         for (int f = 0; f < FLOWS; f++) begin
            held[f]      = 0;
            next_slot[f] = 0;
         end
         pending_classes.delete();
      end else begin
         if (csr_valid && csr_ready)
            bulk_level = csr_data;
         if (req_tvalid && req_tready)
            pending_classes.insert(pending_classes.size(),
                                   classify_flow(req_tuser, req_tdata[5:0],
                                                 req_tdata[37:6]));
         if (rsp_tvalid && rsp_tready) begin
            got.interactive  = rsp_tdata[0];
            got.window_full  = rsp_tdata[1];
            got.sample_count = rsp_tdata[5:2];
            got.peak         = rsp_tdata[37:6];
            if (pending_classes.size() == 0) begin
               if (mismatches < 10)
                  $display("rsp beat with nothing pending: inter=%0b full=%0b cnt=%0d peak=%0h",
                           got.interactive, got.window_full, got.sample_count, got.peak);
               mismatches++;
            end else begin
               want = pending_classes[0];
               pending_classes.delete(0);
               if (got != want) begin
                  if (mismatches < 10)
                     $display({"rsp mismatch at %0t: expected inter=%0b full=%0b cnt=%0d ",
                               "peak=%0h, got inter=%0b full=%0b cnt=%0d peak=%0h"}, $realtime,
                              want.interactive, want.window_full, want.sample_count, want.peak,
                              got.interactive, got.window_full, got.sample_count, got.peak);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= pending_classes.size();
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the flow queue window classifier: clock, reset, stimulus, verdict.
// Depends on fqwc_pkg, flow_queue_window_classifier_top and fqwc_checker.

module tb_top;
   import fqwc_pkg::*;

   localparam int WINDOW        = 8;
   localparam int FLOWS         = 64;
   localparam int HOT_SPAN      = 6;      // flows per phase that get most of the traffic
   localparam int PHASE_ITEMS   = 120;
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int SETTLE_CYCLES = WINDOW + 8;
   localparam int IDLE_LIMIT    = 2000;   // cycles with no beat on any channel
   localparam int REQ_PAD_W     = REQ_DATA_W - OCC_W - FID_W;

   // the encoding left over in the mode field; the block treats it as a query
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [OCC_W-1:0]      csr_data   = '0;

   int               check_fail_count;
   int               pending_count;
   int               idle_cycles = 0;
   logic [OCC_W-1:0] cur_thresh  = THRESH_RESET;
   bit               fast_sender = 1'b0;   // sender offers back to back while set
   bit               long_hold_req = 1'b0; // asks the receiver for one long hold-off
   int               hot_base = 1;
   bit               flat_flow  [FLOWS];
   logic [OCC_W-1:0] flat_level [FLOWS];

   always #2 clock = ~clock;

   flow_queue_window_classifier_top #(
      .WINDOW (WINDOW),
      .FLOWS  (FLOWS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fqwc_checker #(
      .WINDOW (WINDOW),
      .FLOWS  (FLOWS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (check_fail_count),
      .pending_count (pending_count)
   );

   // Watchdog: count cycles in which no beat moves on any channel. The clearing pass
   // after reset and the long hold-off both fit well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Offer one req beat. A zero gap keeps tvalid high and just swaps the data, so
   // tvalid never sees two assignments in one step.
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [FID_W-1:0] fid,
                            input logic [OCC_W-1:0] occ);
      int gap;
      gap = fast_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, occ, fid};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and hold until every outstanding classification has come back.
   // Wait on the clock first so the count includes a beat accepted on the last edge.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   // Write bulk_threshold; first drains all results and lets the block settle so it is idle.
   task automatic write_threshold(input logic [OCC_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cur_thresh = value;
   endtask

   // Pick which flows carry a flat (all equal) sample pattern this phase, and where
   // the hot flows sit in the table.
   task automatic redraw_flow_styles();
      hot_base = $urandom_range(1, FLOWS - HOT_SPAN);
      for (int f = 0; f < FLOWS; f++) begin
         flat_flow[f]  = ($urandom_range(0, 2) == 0);
         flat_level[f] = ($urandom_range(0, 3) == 0) ? '0 : OCC_W'($urandom_range(0, 70000));
      end
   endtask

   // Mostly sample beats on a few hot flows so windows fill and wrap; the rest are
   // queries, forgets, the spare mode, flow zero and stray flows.
   task automatic send_random_item();
      logic [MODE_W-1:0] mode;
      logic [FID_W-1:0]  fid;
      logic [OCC_W-1:0]  occ;
      int                pick;
      if ($urandom_range(0, 39) == 0)
         fast_sender = !fast_sender;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         mode = MODE_ADD;
      else if (pick < 86)
         mode = MODE_QUERY;
      else if (pick < 91)
         mode = MODE_FORGET;
      else
         mode = MODE_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         fid = '0;
      else if (pick < 82)
         fid = FID_W'(hot_base + $urandom_range(0, HOT_SPAN - 1));
      else
         fid = FID_W'($urandom_range(1, FLOWS - 1));
      if (flat_flow[fid] && $urandom_range(0, 7) != 0) begin
         occ = flat_level[fid];
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            occ = OCC_W'($urandom_range(0, 70000));
         else if (pick < 65)
            occ = $urandom;
         else if (pick < 82)
            occ = cur_thresh + OCC_W'($urandom_range(0, 2)) - 1'b1;  // straddle the threshold
         else if (pick < 92)
            occ = OCC_W'($urandom_range(0, 3));
         else
            occ = $urandom_range(0, 1) ? '1 : '0;
      end
      send_item(mode, fid, occ);
   endtask

   // Receiver: random stalls per beat, stretches of steady acceptance, and one long
   // hold-off on request so the output register fills and req_tready drops.
   initial begin : rsp_sink
      int stall;
      bit steady;
      steady = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 39) == 0)
               steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset threshold (65536).
      // Flow zero: samples and forgets are ignored, everything reads back zero.
      send_item(MODE_ADD,    6'd0,  32'hFFFF_FFFF);
      send_item(MODE_FORGET, 6'd0,  32'h0);
      send_item(MODE_QUERY,  6'd0,  32'h0);
      // Top flow id with the largest sample, then the spare mode as a query.
      send_item(MODE_ADD,    6'd63, 32'hFFFF_FFFF);
      send_item(MODE_SPARE,  6'd63, 32'h0);
      // Fill a window with varying small samples; the eighth makes it interactive.
      for (int i = 0; i < WINDOW; i++)
         send_item(MODE_ADD, 6'd5, 32'(100 * i + 1));
      // Wrap the ring: peak one below the threshold, then exactly at it (bulk).
      send_item(MODE_ADD,    6'd5,  32'd65535);
      send_item(MODE_ADD,    6'd5,  32'd65536);
      // Forget the flow and query it.
      send_item(MODE_FORGET, 6'd5,  32'h0);
      send_item(MODE_QUERY,  6'd5,  32'h0);
      // Full window of equal samples: no variance, so never interactive.
      for (int i = 0; i < WINDOW; i++)
         send_item(MODE_ADD, 6'd42, 32'd7);

      // Random phases, each under its own threshold, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_threshold(32'hFFFF_FFFF);
            1: write_threshold(OCC_W'($urandom_range(1000, 100000)));
            2: write_threshold(32'h0);
            3: write_threshold(32'h1);
            default: write_threshold(THRESH_RESET);
         endcase
         redraw_flow_styles();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // keep offering beats while the receiver holds off
            if (phase == 1 && n == 40)
               long_hold_req = 1'b1;
            // sender pause until every result is back
            if (phase == 3 && n == 60)
               drain_results();
            send_random_item();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (check_fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fqwc_pkg.sv
rtl/fqwc_sample_ram.sv
rtl/fqwc_flow_table.sv
rtl/fqwc_window_scan.sv
rtl/flow_queue_window_classifier_top.sv
verif/fqwc_checker.sv
verif/tb_top.sv
